[design/mtd_pkg.sv]
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types, character codes and the letter lookup for the Morse token
// decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int CHAR_W = 16;
    localparam int CODE_W = 11;
    localparam int PAT_W  = 5;
    localparam int LEN_W  = 3;

    localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_DASH  = 16'h002D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_SLASH = 16'h002F;

    localparam logic [LEN_W-1:0]  LEN_MAX_SYM = 3'd5;
    localparam logic [LEN_W-1:0]  LEN_SAT     = 3'd6;
    localparam logic [CODE_W-1:0] CODE_SPACE  = 11'h020;
    localparam logic [CODE_W-1:0] CODE_NONE   = 11'h000;

    // Pending token. Bit i of pattern is set when symbol i is a dash.
    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length;
        logic             bad;
        logic             is_slash;
    } tok_state_t;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
    } tok_result_t;

    // Index is (2^length - 2) + pattern; zero means no letter.
    function automatic logic [CODE_W-1:0] letter_code(input logic [5:0] idx);
        logic [CODE_W-1:0] code;
        case (idx)
            6'd0:    code = 11'h415;
            6'd1:    code = 11'h422;
            6'd2:    code = 11'h406;
            6'd3:    code = 11'h41D;
            6'd4:    code = 11'h410;
            6'd5:    code = 11'h41C;
            6'd6:    code = 11'h421;
            6'd7:    code = 11'h414;
            6'd8:    code = 11'h420;
            6'd9:    code = 11'h490;
            6'd10:   code = 11'h423;
            6'd11:   code = 11'h41A;
            6'd12:   code = 11'h412;
            6'd13:   code = 11'h41E;
            6'd14:   code = 11'h425;
            6'd15:   code = 11'h411;
            6'd16:   code = 11'h41B;
            6'd17:   code = 11'h417;
            6'd18:   code = 11'h424;
            6'd19:   code = 11'h426;
            6'd20:   code = 11'h41F;
            6'd21:   code = 11'h427;
            6'd22:   code = 11'h416;
            6'd23:   code = 11'h42C;
            6'd24:   code = 11'h42F;
            6'd25:   code = 11'h429;
            6'd26:   code = 11'h42E;
            6'd28:   code = 11'h419;
            6'd29:   code = 11'h428;
            6'd34:   code = 11'h404;
            6'd44:   code = 11'h407;
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

[design/mtd_token_step.sv]
// ----------------------------------------------------------------------------
// mtd_token_step
// Combinational update of the pending token for one character, with the
// classification of the token when whitespace or the end flag closes it.
// ----------------------------------------------------------------------------
module mtd_token_step (
    input  mtd_pkg::tok_state_t      cur_state,
    input  logic [mtd_pkg::CHAR_W-1:0] in_char,
    input  logic                     end_of_text,
    output mtd_pkg::tok_state_t      next_state,
    output mtd_pkg::tok_result_t     result
);
    import mtd_pkg::*;

    logic       is_space;
    logic       is_dot;
    logic       is_dash;
    logic       is_sym;
    logic       is_slash;
    logic       do_flush;
    tok_state_t added;
    tok_state_t flushed;
    logic [5:0] idx;

    assign is_space = (in_char == CH_SPACE) || ((in_char >= CH_TAB) && (in_char <= CH_CR));
    assign is_dot   = (in_char == CH_DOT);
    assign is_dash  = (in_char == CH_DASH);
    assign is_sym   = is_dot || is_dash;
    assign is_slash = (in_char == CH_SLASH);

    // Token with the current character appended.
    always_comb begin
        added = cur_state;
        if (is_sym) begin
            if (cur_state.is_slash) begin
                added.bad = 1'b1;
            end
            if (is_dash && (cur_state.length < LEN_MAX_SYM)) begin
                added.pattern = cur_state.pattern | PAT_W'(5'd1 << cur_state.length);
            end
        end else if (is_slash) begin
            if (cur_state.length == '0) begin
                added.is_slash = 1'b1;
            end else begin
                added.bad = 1'b1;
            end
        end else begin
            added.bad = 1'b1;
        end
        if (cur_state.length < LEN_SAT) begin
            added.length = cur_state.length + LEN_W'(1);
        end
    end

    // Whitespace closes the token as it stands; the end flag closes it after
    // the character has been added.
    assign flushed  = is_space ? cur_state : added;
    assign do_flush = is_space || end_of_text;

    assign idx = (6'd1 << flushed.length) - 6'd2 + {1'b0, flushed.pattern};

    always_comb begin
        result.code = CODE_NONE;
        if (!flushed.bad && (flushed.length != '0)) begin
            if (flushed.is_slash) begin
                if (flushed.length == LEN_W'(1)) begin
                    result.code = CODE_SPACE;
                end
            end else if (flushed.length <= LEN_MAX_SYM) begin
                result.code = letter_code(idx);
            end
        end
        result.emit = do_flush && (result.code != CODE_NONE);
    end

    assign next_state = do_flush ? '0 : added;

endmodule

[design/morse_token_decoder_core.sv]
// ----------------------------------------------------------------------------
// morse_token_decoder_core
// Splits a stream of Unicode characters at whitespace and decodes each Morse
// token into a Cyrillic letter code point or a word space.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                     tlast
//  s_axis    in         [15:0] character          end of text
//  m_axis    out        [10:0] code point         -
//
//  One character per cycle is sustained while the result is not stalled. A
//  taken character is held in the input register and decoded into the result
//  register, from which its result is offered on m_axis.
//  Reset clears the token state and both valid flags.
//  A stalled result holds the pipeline: the input register takes one more
//  character and s_axis_tready then stays low until the result is taken,
//  whether or not that character gives a result.
// ----------------------------------------------------------------------------
module morse_token_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] in_char
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [10:0] out_char, [15:11] zero
);
    import mtd_pkg::*;

    logic              in_vld_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    tok_state_t        tok_reg;
    tok_state_t        tok_next;
    tok_result_t       res;
    logic              out_vld_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_free;
    logic              proc;

    mtd_token_step u_step (
        .cur_state   (tok_reg),
        .in_char     (in_char_reg),
        .end_of_text (in_last_reg),
        .next_state  (tok_next),
        .result      (res)
    );

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign proc          = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            tok_reg     <= '0;
        end else begin
            if (s_axis_tready) begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (proc) begin
                tok_reg     <= tok_next;
                out_vld_reg <= res.emit;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (proc && res.emit) begin
            out_code_reg <= res.code;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, out_code_reg};

endmodule

[design/mtd_checker.sv]
// ----------------------------------------------------------------------------
// mtd_checker
// Port-level checks for the Morse token decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mtd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A held result keeps its data until the transaction completes.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An offered character stays put until its transaction completes.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("character changed while stalled");

    // Only a word space or a Cyrillic letter is ever produced.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[15:11] == 5'd0) &&
            ((m_axis_tdata[10:0] == 11'h020) ||
             ((m_axis_tdata[10:0] >= 11'h404) && (m_axis_tdata[10:0] <= 11'h490))))
        else $error("result outside the letter range");

    // With no result waiting, the input side never stalls.
    a_in_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with the output empty");

    // A new result follows a taken character, through the input and result registers.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a character two cycles earlier");

endmodule

bind morse_token_decoder_core mtd_checker u_mtd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
